// File: rtl/frl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and codes for the framed record receiver
// no dependencies

package frl_pkg;

   // payload capacity of one bank and the record chain that follows from it
   localparam int MAX_PAYLOAD_BYTES = 128;
   localparam int NUM_CELLS         = MAX_PAYLOAD_BYTES / 4;
   localparam int POS_W             = 8;
   localparam int REC_IDX_W         = 6;

   // operation codes
   localparam logic [1:0] OP_LINK_BYTE   = 2'd0;
   localparam logic [1:0] OP_CMD_LOOKUP  = 2'd1;
   localparam logic [1:0] OP_DATA_LOOKUP = 2'd2;

   // frame status codes
   localparam logic [1:0] ST_NONE      = 2'd0;
   localparam logic [1:0] ST_COMMITTED = 2'd1;
   localparam logic [1:0] ST_BAD_SUM   = 2'd2;
   localparam logic [1:0] ST_TOO_LONG  = 2'd3;

   // protocol constants
   localparam logic [7:0]  START_MARKER   = 8'h7E;
   localparam logic [7:0]  CMD_LOW_SEL    = 8'h01;
   localparam logic [7:0]  CMD_HIGH_SEL   = 8'h10;
   localparam logic [15:0] NOT_FOUND_WORD = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_ORIGIN,
      PH_DEST,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] rx_byte;
      logic [7:0] lookup_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  frame_status;
      logic        found;
      logic [15:0] command_word;
      logic [7:0]  data_command;
      logic [15:0] data_payload;
      logic [7:0]  frame_origin;
      logic [7:0]  frame_destination;
      logic [5:0]  record_count;
   } rsp_type;

   // staging bank write from the parser to the cells
   typedef struct packed {
      logic             en;
      logic             bank;
      logic [POS_W-1:0] pos;
      logic [7:0]       data;
   } wr_type;

   // committed frame as seen by the cells and the result path
   typedef struct packed {
      logic                 active_bank;
      logic [7:0]           origin;
      logic [7:0]           destination;
      logic [REC_IDX_W-1:0] count;
   } view_type;

   // lookup token passed down the record chain
   typedef struct packed {
      logic        valid;
      logic        is_cmd;
      logic [7:0]  id;
      logic        found;
      logic [15:0] cword;
      logic [7:0]  dcmd;
      logic [15:0] dpay;
   } tok_type;

endpackage

`default_nettype wire

// File: rtl/frl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one record cell: holds a four-byte record for each bank and checks the lookup token
// depends on frl_pkg

module frl_cell
   import frl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [REC_IDX_W-1:0] cell_index,
   input  wire wr_type               wr,
   input  wire view_type             view,
   input  wire tok_type              tok_up,
   output tok_type                   tok_down
);

   logic [1:0][3:0][7:0] rec_ff;
   logic [1:0][3:0][7:0] rec_in;
   logic [3:0][7:0]      rec;
   tok_type              tok_ff;
   tok_type              tok_in;

   always_comb begin
      rec_in = rec_ff;
      if (wr.en && (wr.pos[POS_W-1:2] == cell_index)) begin
         rec_in[wr.bank][wr.pos[1:0]] = wr.data;
      end
   end

   assign rec = rec_ff[view.active_bank];

   // first match wins: a token already marked found passes unchanged
   always_comb begin
      tok_in = tok_up;
      if (tok_up.valid && !tok_up.found && (cell_index < view.count) &&
          (rec[0] == tok_up.id)) begin
         if (tok_up.is_cmd) begin
            if (rec[1] == CMD_LOW_SEL) begin
               tok_in.found = 1'b1;
               tok_in.cword = {CMD_LOW_SEL, rec[3]};
            end else if (rec[1] == CMD_HIGH_SEL) begin
               tok_in.found = 1'b1;
               tok_in.cword = {CMD_HIGH_SEL, rec[2]};
            end
         end else begin
            tok_in.found = 1'b1;
            tok_in.dcmd  = rec[1];
            tok_in.dpay  = {rec[2], rec[3]};
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   // only the valid bit needs a reset
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.is_cmd <= tok_in.is_cmd;
      tok_ff.id     <= tok_in.id;
      tok_ff.found  <= tok_in.found;
      tok_ff.cword  <= tok_in.cword;
      tok_ff.dcmd   <= tok_in.dcmd;
      tok_ff.dpay   <= tok_in.dpay;
   end

   assign tok_down = tok_ff;

endmodule

`default_nettype wire

// File: rtl/frl_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// link byte parser: framing, checksum, staging writes and bank commit
// depends on frl_pkg

module frl_parser
   import frl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_valid,
   input  wire logic [7:0] rx_byte,
   output logic [1:0]      status,
   output wr_type          wr,
   output view_type        view
);

   phase_type            phase_ff, phase_in;
   logic [7:0]           pend_origin_ff, pend_origin_in;
   logic [7:0]           pend_dest_ff, pend_dest_in;
   logic [7:0]           pend_len_ff, pend_len_in;
   logic [7:0]           taken_ff, taken_in;
   logic [7:0]           sum_ff, sum_in;
   logic                 bank_ff, bank_in;
   logic [7:0]           com_origin_ff, com_origin_in;
   logic [7:0]           com_dest_ff, com_dest_in;
   logic [REC_IDX_W-1:0] com_count_ff, com_count_in;
   logic                 too_long;
   logic                 last_byte;
   logic                 sum_ok;

   assign too_long  = rx_byte > 8'(MAX_PAYLOAD_BYTES);
   assign last_byte = ({1'b0, taken_ff} + 9'd1) >= {1'b0, pend_len_ff};
   assign sum_ok    = rx_byte == ~sum_ff;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (byte_valid) begin
         case (phase_ff)
            PH_HUNT:    phase_in = (rx_byte == START_MARKER) ? PH_ORIGIN : PH_HUNT;
            PH_ORIGIN:  phase_in = PH_DEST;
            PH_DEST:    phase_in = PH_LENGTH;
            PH_LENGTH: begin
               if (too_long) begin
                  phase_in = PH_HUNT;
               end else begin
                  phase_in = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: phase_in = last_byte ? PH_CHECK : PH_PAYLOAD;
            PH_CHECK:   phase_in = PH_HUNT;
            default:    phase_in = PH_HUNT;
         endcase
      end
   end

   // outputs and datapath
   always_comb begin
      status        = ST_NONE;
      wr.en         = 1'b0;
      wr.bank       = ~bank_ff;
      wr.pos        = taken_ff;
      wr.data       = rx_byte;
      pend_origin_in = pend_origin_ff;
      pend_dest_in   = pend_dest_ff;
      pend_len_in    = pend_len_ff;
      taken_in       = taken_ff;
      sum_in         = sum_ff;
      bank_in        = bank_ff;
      com_origin_in  = com_origin_ff;
      com_dest_in    = com_dest_ff;
      com_count_in   = com_count_ff;
      if (byte_valid) begin
         case (phase_ff)
            PH_ORIGIN: pend_origin_in = rx_byte;
            PH_DEST:   pend_dest_in = rx_byte;
            PH_LENGTH: begin
               if (too_long) begin
                  status = ST_TOO_LONG;
               end else begin
                  pend_len_in = rx_byte;
                  taken_in    = 8'd0;
                  sum_in      = 8'd0;
               end
            end
            PH_PAYLOAD: begin
               wr.en    = 1'b1;
               sum_in   = sum_ff + rx_byte;
               taken_in = taken_ff + 8'd1;
            end
            PH_CHECK: begin
               if (sum_ok) begin
                  status        = ST_COMMITTED;
                  bank_in       = ~bank_ff;
                  com_origin_in = pend_origin_ff;
                  com_dest_in   = pend_dest_ff;
                  com_count_in  = pend_len_ff[POS_W-1:2];
               end else begin
                  status = ST_BAD_SUM;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         pend_origin_ff <= 8'd0;
         pend_dest_ff   <= 8'd0;
         pend_len_ff    <= 8'd0;
         taken_ff       <= 8'd0;
         sum_ff         <= 8'd0;
         bank_ff        <= 1'b0;
         com_origin_ff  <= 8'd0;
         com_dest_ff    <= 8'd0;
         com_count_ff   <= '0;
      end else begin
         phase_ff       <= phase_in;
         pend_origin_ff <= pend_origin_in;
         pend_dest_ff   <= pend_dest_in;
         pend_len_ff    <= pend_len_in;
         taken_ff       <= taken_in;
         sum_ff         <= sum_in;
         bank_ff        <= bank_in;
         com_origin_ff  <= com_origin_in;
         com_dest_ff    <= com_dest_in;
         com_count_ff   <= com_count_in;
      end
   end

   // committed view after this byte; equals the stored view when no byte comes in
   assign view.active_bank = bank_in;
   assign view.origin      = com_origin_in;
   assign view.destination = com_dest_in;
   assign view.count       = com_count_in;

endmodule

`default_nettype wire

// File: rtl/framed_record_receiver_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// framed record receiver with record lookup: top level
// depends on frl_pkg, frl_parser, frl_cell
//
// req_ channel carries one transaction per link byte or lookup; rsp_ channel returns
// exactly one result transaction for each, in order.
// link bytes (and the unused operation code) answer in the cycle after acceptance and may
// follow back to back, one per cycle, as long as rsp_ready keeps up.
// a lookup token enters the record chain, moves one cell per cycle through the cell
// registers, one per four-byte record, and then loads the output register.
// no new transaction is taken while a lookup is in the chain.
// a single output register holds the result; while it is full and rsp_ready is low,
// req_ready stays low and nothing is lost. when it is being taken, a new transaction
// can be accepted in the same cycle.
// reset (synchronous) puts the parser in start-marker hunt, clears the committed frame
// (origin, destination, record count zero) and empties the chain and output register.
// record contents are not cleared: only records of the committed frame are ever read.

module framed_record_receiver_lookup
   import frl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic     busy_ff, busy_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;
   logic     accept;
   logic     is_lookup;
   logic     byte_valid;
   logic     load;
   logic [1:0] status;
   wr_type   wr;
   view_type view;
   tok_type  tok_head;
   tok_type  tok_chain [NUM_CELLS+1];
   tok_type  tok_last;

   // one transaction in flight at most; output slot must be free or draining
   assign req_ready  = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign is_lookup  = (req_data.operation == OP_CMD_LOOKUP) ||
                       (req_data.operation == OP_DATA_LOOKUP);
   assign byte_valid = accept && (req_data.operation == OP_LINK_BYTE);

   frl_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req_data.rx_byte),
      .status     (status),
      .wr         (wr),
      .view       (view)
   );

   // lookup token: command lookups default to the not-found word
   always_comb begin
      tok_head.valid  = accept && is_lookup;
      tok_head.is_cmd = req_data.operation == OP_CMD_LOOKUP;
      tok_head.id     = req_data.lookup_id;
      tok_head.found  = 1'b0;
      tok_head.cword  = (req_data.operation == OP_CMD_LOOKUP) ? NOT_FOUND_WORD : 16'd0;
      tok_head.dcmd   = 8'd0;
      tok_head.dpay   = 16'd0;
   end

   assign tok_chain[0] = tok_head;

   // record chain, one cell per four-byte record
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      frl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (REC_IDX_W'(i)),
         .wr         (wr),
         .view       (view),
         .tok_up     (tok_chain[i]),
         .tok_down   (tok_chain[i+1])
      );
   end

   assign tok_last = tok_chain[NUM_CELLS];

   // result register load: immediate answers or a token leaving the chain
   assign load = (accept && !is_lookup) || tok_last.valid;

   always_comb begin
      busy_in = busy_ff;
      if (accept && is_lookup) begin
         busy_in = 1'b1;
      end else if (tok_last.valid) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_data_in                   = rsp_data_ff;
      if (load) begin
         rsp_data_in.frame_origin      = view.origin;
         rsp_data_in.frame_destination = view.destination;
         rsp_data_in.record_count      = view.count;
         if (tok_last.valid) begin
            rsp_data_in.frame_status = ST_NONE;
            rsp_data_in.found        = tok_last.found;
            rsp_data_in.command_word = tok_last.cword;
            rsp_data_in.data_command = tok_last.dcmd;
            rsp_data_in.data_payload = tok_last.dpay;
         end else begin
            rsp_data_in.frame_status = byte_valid ? status : ST_NONE;
            rsp_data_in.found        = 1'b0;
            rsp_data_in.command_word = 16'd0;
            rsp_data_in.data_command = 8'd0;
            rsp_data_in.data_payload = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: test/tb_framed_record_receiver_lookup.sv
`timescale 1ns / 1ps
// self-checking testbench for the framed record receiver with record lookup
// depends on frl_pkg and framed_record_receiver_lookup; predicts every result transaction

module tb_framed_record_receiver_lookup;
   import frl_pkg::*;

   // the fourth operation code has no name in the package
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int LONG_HOLD_CYCLES  = 150;
   localparam int RANDOM_ITEMS      = 1100;
   localparam int DRAIN_LIMIT       = 20000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   framed_record_receiver_lookup dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // shared bookkeeping
   // ---------------------------------------------------------------------------
   rsp_type    expected_results[$];
   int         mismatch_count = 0;
   int         items_sent     = 0;
   bit         no_gaps        = 1'b0;   // both sides run flat out while set
   int         hold_requests  = 0;      // raised by a test, served by the receiver
   int         holds_done     = 0;
   logic [7:0] frame_body[$];           // payload of the next frame to send
   logic [7:0] id_base        = 8'h00;  // ids cluster around this so lookups hit

   // ---------------------------------------------------------------------------
   // predicted receiver state
   // ---------------------------------------------------------------------------
   phase_type  rx_phase    = PH_HUNT;
   logic [7:0] hold_origin = '0;
   logic [7:0] hold_dest   = '0;
   logic [7:0] hold_len    = '0;
   logic [7:0] taken       = '0;
   logic [7:0] payload_sum = '0;
   logic [7:0] bank_mem [0:2*MAX_PAYLOAD_BYTES-1];
   logic       cur_bank    = 1'b0;
   logic [7:0] cur_origin  = '0;
   logic [7:0] cur_dest    = '0;
   logic [5:0] cur_records = '0;

   // advance the predicted receiver by one transaction and return its answer
   function automatic rsp_type predict_result(input req_type item);
      rsp_type    res;
      int         base;
      int         p;
      logic [7:0] b;
      logic [7:0] cmd;
      res  = '0;
      b    = item.rx_byte;
      base = cur_bank ? MAX_PAYLOAD_BYTES : 0;
      case (item.operation)
         OP_LINK_BYTE: begin
            case (rx_phase)
               PH_ORIGIN: begin
                  hold_origin = b;
                  rx_phase    = PH_DEST;
               end
               PH_DEST: begin
                  hold_dest = b;
                  rx_phase  = PH_LENGTH;
               end
               PH_LENGTH: begin
                  // oversize length aborts at once, the rest is hunted through
                  if (b > MAX_PAYLOAD_BYTES) begin
                     res.frame_status = ST_TOO_LONG;
                     rx_phase         = PH_HUNT;
                  end else begin
                     hold_len    = b;
                     taken       = '0;
                     payload_sum = '0;
                     rx_phase    = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  // payload lands in the bank that is not active
                  bank_mem[(cur_bank ? 0 : MAX_PAYLOAD_BYTES) + taken] = b;
                  payload_sum = payload_sum + b;
                  taken       = taken + 8'd1;
                  if (taken >= hold_len)
                     rx_phase = PH_CHECK;
               end
               PH_CHECK: begin
                  rx_phase = PH_HUNT;
                  if (b == 8'(8'hFF - payload_sum)) begin
                     cur_bank         = ~cur_bank;
                     cur_origin       = hold_origin;
                     cur_dest         = hold_dest;
                     cur_records      = hold_len[7:2];
                     res.frame_status = ST_COMMITTED;
                  end else begin
                     res.frame_status = ST_BAD_SUM;
                  end
               end
               default: rx_phase = (b == START_MARKER) ? PH_ORIGIN : PH_HUNT;
            endcase
         end
         OP_CMD_LOOKUP: begin
            // records with the id but another command are passed over
            res.command_word = NOT_FOUND_WORD;
            for (int r = 0; r < cur_records && !res.found; r++) begin
               p = base + 4 * r;
               if (bank_mem[p] == item.lookup_id) begin
                  cmd = bank_mem[p + 1];
                  if (cmd == CMD_LOW_SEL) begin
                     res.command_word = {CMD_LOW_SEL, bank_mem[p + 3]};
                     res.found        = 1'b1;
                  end else if (cmd == CMD_HIGH_SEL) begin
                     res.command_word = {CMD_HIGH_SEL, bank_mem[p + 2]};
                     res.found        = 1'b1;
                  end
               end
            end
         end
         OP_DATA_LOOKUP: begin
            for (int r = 0; r < cur_records && !res.found; r++) begin
               p = base + 4 * r;
               if (bank_mem[p] == item.lookup_id) begin
                  res.data_command = bank_mem[p + 1];
                  res.data_payload = {bank_mem[p + 2], bank_mem[p + 3]};
                  res.found        = 1'b1;
               end
            end
         end
         default: ;
      endcase
      res.frame_origin      = cur_origin;
      res.frame_destination = cur_dest;
      res.record_count      = cur_records;
      return res;
   endfunction

   // mostly no gap, some short ones, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------
   // offer one transaction, wait for the handshake, then log its expected answer;
   // valid stays high on return so back-to-back transactions need no extra edge
   task automatic send_item(input req_type item);
      int gap;
      bit ignored;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      ignored = (item.operation == OP_UNUSED) ||
                (item.operation == OP_LINK_BYTE && rx_phase == PH_HUNT &&
                 item.rx_byte != START_MARKER);
      if (!ignored)
         items_sent++;
      expected_results.push_back(predict_result(item));
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_type item;
      item.operation = OP_LINK_BYTE;
      item.rx_byte   = b;
      item.lookup_id = 8'($urandom);
      send_item(item);
   endtask

   task automatic send_lookup(input logic [1:0] op, input logic [7:0] id);
      req_type item;
      item.operation = op;
      item.rx_byte   = 8'($urandom);
      item.lookup_id = id;
      send_item(item);
   endtask

   // marker, header, frame_body, checksum (optionally spoiled)
   task automatic send_frame(input logic [7:0] origin, input logic [7:0] dest,
                             input bit corrupt);
      logic [7:0] total;
      total = '0;
      send_byte(START_MARKER);
      send_byte(origin);
      send_byte(dest);
      send_byte(8'(frame_body.size()));
      foreach (frame_body[i]) begin
         send_byte(frame_body[i]);
         total = total + frame_body[i];
      end
      if (corrupt)
         send_byte(8'(8'hFF - total) ^ 8'($urandom_range(1, 255)));
      else
         send_byte(8'(8'hFF - total));
   endtask

   // mostly ids near id_base, biased toward the two selectable commands
   task automatic build_records(input int nrec, input int extra);
      int pick;
      frame_body.delete();
      for (int r = 0; r < nrec; r++) begin
         pick = $urandom_range(0, 99);
         frame_body.push_back((pick < 70) ? 8'(id_base + $urandom_range(0, 7))
                                          : 8'($urandom));
         pick = $urandom_range(0, 99);
         frame_body.push_back((pick < 35) ? CMD_LOW_SEL :
                              (pick < 70) ? CMD_HIGH_SEL : 8'($urandom));
         frame_body.push_back(8'($urandom));
         frame_body.push_back(8'($urandom));
      end
      repeat (extra) frame_body.push_back(8'($urandom));
   endtask

   task automatic send_some_lookups(input int n);
      int         pick;
      logic [1:0] op;
      logic [7:0] id;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         op   = (pick < 45) ? OP_CMD_LOOKUP : (pick < 92) ? OP_DATA_LOOKUP : OP_UNUSED;
         id   = ($urandom_range(0, 99) < 80) ? 8'(id_base + $urandom_range(0, 7))
                                             : 8'($urandom);
         send_lookup(op, id);
      end
   endtask

   // zeros walk any half-parsed frame out to a checksum and back to hunt
   task automatic resync_parser();
      while (rx_phase != PH_HUNT)
         send_byte(8'h00);
   endtask

   // ---------------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------------
   // random stalls, plus a long hold-off whenever a test asks for one
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else begin
            n = idle_len();
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // every accepted result transaction is matched against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with nothing expected");
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("frame_status",      want.frame_status,      rsp_data.frame_status);
            check_field("found",             want.found,             rsp_data.found);
            check_field("command_word",      want.command_word,      rsp_data.command_word);
            check_field("data_command",      want.data_command,      rsp_data.data_command);
            check_field("data_payload",      want.data_payload,      rsp_data.data_payload);
            check_field("frame_origin",      want.frame_origin,      rsp_data.frame_origin);
            check_field("frame_destination", want.frame_destination,
                        rsp_data.frame_destination);
            check_field("record_count",      want.record_count,      rsp_data.record_count);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------
   // nothing committed yet: no records to scan, extreme ids, unused code
   task automatic test_empty_lookups();
      send_lookup(OP_CMD_LOOKUP, 8'h00);
      send_lookup(OP_DATA_LOOKUP, 8'hFF);
      send_lookup(OP_UNUSED, 8'h55);
   endtask

   task automatic test_malformed_frames();
      // marker as origin is plain data; zero length wants checksum 0xFF, gets 0x00
      send_byte(START_MARKER);
      send_byte(START_MARKER);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      // good zero-length frame commits an empty record set
      frame_body.delete();
      send_frame(8'hFF, 8'h00, 1'b0);
      // one past capacity is refused at the length byte
      send_byte(START_MARKER);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'(MAX_PAYLOAD_BYTES + 1));
   endtask

   // first record has the id but an unselectable command, second answers the command lookup;
   // a marker byte sits inside the payload
   task automatic test_record_lookups();
      frame_body = '{8'h05, 8'h02, 8'h7E, 8'hBB, 8'h05, 8'h10, 8'hCC, 8'hDD};
      send_frame(8'h01, 8'h02, 1'b0);
      send_lookup(OP_CMD_LOOKUP, 8'h05);
      send_lookup(OP_DATA_LOOKUP, 8'h05);
      send_lookup(OP_CMD_LOOKUP, 8'hFF);
   endtask

   // receiver stops while the sender keeps pushing, so the input has to stall
   task automatic test_backpressure();
      hold_requests++;
      no_gaps = 1'b1;
      repeat (30) send_byte(8'($urandom));
      send_some_lookups(3);
      no_gaps = 1'b0;
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int pick;
      int nrec;
      int extra;
      stop_at = items_sent + RANDOM_ITEMS;
      id_base = 8'($urandom);
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 19) == 0)
            no_gaps = ~no_gaps;
         if ($urandom_range(0, 39) == 0)
            id_base = 8'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            // well-formed frame with random records, now and then full capacity
            resync_parser();
            nrec  = ($urandom_range(0, 99) < 5) ? MAX_PAYLOAD_BYTES / 4
                                                : $urandom_range(0, 6);
            extra = (nrec * 4 + 3 <= MAX_PAYLOAD_BYTES) ? $urandom_range(0, 3) : 0;
            build_records(nrec, extra);
            send_frame(8'($urandom), 8'($urandom), 1'b0);
            send_some_lookups($urandom_range(1, 4));
         end else if (pick < 65) begin
            send_some_lookups($urandom_range(1, 3));
         end else if (pick < 75) begin
            resync_parser();
            build_records($urandom_range(0, 4), $urandom_range(0, 3));
            send_frame(8'($urandom), 8'($urandom), 1'b1);
         end else if (pick < 82) begin
            // oversize length followed by leftover frame bytes
            resync_parser();
            send_byte(START_MARKER);
            send_byte(8'($urandom));
            send_byte(8'($urandom));
            send_byte(8'($urandom_range(MAX_PAYLOAD_BYTES + 1, 255)));
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end else begin
            // frame cut short inside its header
            resync_parser();
            send_byte(START_MARKER);
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
         end
      end
      no_gaps = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // sequencing
   // ---------------------------------------------------------------------------
   initial begin
      int waited;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_lookups();
      test_malformed_frames();
      test_record_lookups();
      test_backpressure();
      test_random_traffic();

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then give a lookup's worth of cycles for anything unexpected
      waited = 0;
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_results.size() != 0) begin
         $error("%0d result transactions never arrived", expected_results.size());
         mismatch_count++;
      end
      repeat (NUM_CELLS + 4) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb_framed_record_receiver_lookup: clean");
      else
         $display("tb_framed_record_receiver_lookup: errors");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #15_000_000;
      $display("tb_framed_record_receiver_lookup: errors");
      $finish;
   end

endmodule
